FILE: rtl/point_curvature_window_macros.svh
// ----------------------------------------------------------------------------
// point_curvature_window assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_CURVATURE_WINDOW_MACROS_SVH
`define POINT_CURVATURE_WINDOW_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on aclk, with aresetn low disabling the check
`define PCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk at every edge, reset included
`define PCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PCW_ASSERT(lbl, prop, msg)
`define PCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/pcw_pkg.sv
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared widths and control types of the point curvature window.
// ----------------------------------------------------------------------------
`default_nettype none

package pcw_pkg;

    // Fixed field widths of the stream payload
    localparam int IN_COORD_W = 18;
    localparam int IDX_W      = 16;
    localparam int CURV_W     = 45;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 64;

    // Pipeline control handed from the top level to each axis unit
    typedef struct packed {
        logic shift;    // point enters the window
        logic advance;  // pipeline stages move one step
    } pcw_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/point_curvature_window.sv
// ----------------------------------------------------------------------------
// point_curvature_window
// Streaming lidar point curvature over a sliding window of 2*HALF_WINDOW+1.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                     | Meaning
// s_      | in  | tdata: x_mm[17:0] y_mm[35:18] z_mm[53:36]   | one point
//         |     | tuser: cloud_start                          |
// m_      | out | tdata: centre_index[15:0] curvature[60:16]  | one curvature
//
// One point per cycle is taken while the result side keeps up. The window
// loads at the point's transfer edge; difference, square and output register
// follow in that order at the edges on which the pipeline advances, and
// m_tvalid rises as the output register loads. The pipeline stalls as a
// whole: s_tready is low only while the output register holds a result that
// is not taken. Reset clears the window, its running sums and the point
// count. A point that arrives after the cloud reached MAX_POINTS is taken
// and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_curvature_window_macros.svh"

module point_curvature_window #(
    parameter int HALF_WINDOW = 5,
    parameter int COORD_BITS  = 18,
    parameter int MAX_POINTS  = 65536
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pcw_pkg::S_TDATA_W-1:0]   s_tdata,  // x_mm, y_mm, z_mm, zero pad
    input  wire logic                            s_tuser,  // cloud_start
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pcw_pkg::M_TDATA_W-1:0]        m_tdata   // centre_index, curvature, zero pad
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int POINT_W = 3 * COORD_BITS;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W  = COORD_BITS + $clog2(4 * HALF_WINDOW) + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int IDX_W   = pcw_pkg::IDX_W;
    localparam int CURV_W  = pcw_pkg::CURV_W;
    localparam int CIN_W   = pcw_pkg::IN_COORD_W;

    // ------------------------------------------------------------------
    // Transfer control
    // ------------------------------------------------------------------
    pcw_pkg::pcw_ctrl_t ctrl;
    logic               in_xfer;
    logic [CNT_W-1:0]   count_base;
    logic               keep_point;
    logic               fire;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               c_valid_reg;
    logic               m_valid_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic [IDX_W-1:0]   a_idx_next;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [IDX_W-1:0]   c_idx_reg;
    logic [IDX_W-1:0]   m_idx_reg;
    logic [CURV_W-1:0]  m_curv_reg;
    logic [CURV_W-1:0]  m_curv_next;

    // Advance the whole pipeline unless the output register is stuck
    assign ctrl.advance = !m_valid_reg || m_tready;
    assign s_tready     = ctrl.advance;
    assign in_xfer      = s_tvalid && s_tready;

    // A new cloud restarts the count before its first point is counted
    assign count_base = s_tuser ? '0 : count_reg;
    assign keep_point = count_base < CNT_W'(MAX_POINTS);
    assign ctrl.shift = in_xfer && keep_point;
    assign fire       = ctrl.shift && (count_base >= CNT_W'(2 * HALF_WINDOW));
    assign count_next = count_base + CNT_W'(1);
    assign a_idx_next = IDX_W'(count_base - CNT_W'(HALF_WINDOW));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.shift) begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Window: row of cells, oldest point in cell 0, centre in the middle
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] x_cut;
    logic [COORD_BITS-1:0] y_cut;
    logic [COORD_BITS-1:0] z_cut;
    logic [POINT_W-1:0]    new_point;
    logic [POINT_W-1:0]    win [WIN_LEN];

    // Keep the low COORD_BITS bits of each coordinate
    assign x_cut     = COORD_BITS'(s_tdata[CIN_W-1:0]);
    assign y_cut     = COORD_BITS'(s_tdata[2*CIN_W-1:CIN_W]);
    assign z_cut     = COORD_BITS'(s_tdata[3*CIN_W-1:2*CIN_W]);
    assign new_point = {z_cut, y_cut, x_cut};

    for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
        logic [POINT_W-1:0] cell_in;
        if (k == WIN_LEN - 1) begin : g_head
            assign cell_in = new_point;
        end else begin : g_link
            assign cell_in = win[k+1];
        end
        pcw_cell #(
            .POINT_W (POINT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (ctrl.shift),
            .point_in  (cell_in),
            .point_out (win[k])
        );
    end

    // ------------------------------------------------------------------
    // Per-axis sum, difference and square
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] square [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        pcw_axis #(
            .COORD_BITS  (COORD_BITS),
            .HALF_WINDOW (HALF_WINDOW)
        ) u_axis (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .new_coord    ($signed(new_point[a*COORD_BITS +: COORD_BITS])),
            .old_coord    ($signed(win[0][a*COORD_BITS +: COORD_BITS])),
            .centre_coord ($signed(win[HALF_WINDOW][a*COORD_BITS +: COORD_BITS])),
            .square       (square[a])
        );
    end

    // Sum the three squares and keep the low curvature bits
    logic [SQ_W+1:0] curv_sum;
    assign curv_sum    = (SQ_W+2)'(square[0]) + (SQ_W+2)'(square[1]) + (SQ_W+2)'(square[2]);
    assign m_curv_next = CURV_W'(curv_sum);

    // ------------------------------------------------------------------
    // Valid and index pipeline, output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            a_valid_reg <= fire;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            a_idx_reg  <= a_idx_next;
            b_idx_reg  <= a_idx_reg;
            c_idx_reg  <= b_idx_reg;
            m_idx_reg  <= c_idx_reg;
            m_curv_reg <= m_curv_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pcw_pkg::M_TDATA_W'({m_curv_reg, m_idx_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PCW_ASSERT(a_stall_blocks_input, (m_tvalid && !m_tready) |-> !s_tready,
                "input taken while output stalled")
    `PCW_ASSERT(a_count_bounded, count_reg <= CNT_W'(MAX_POINTS),
                "point count beyond cloud limit")
    `PCW_ASSERT(a_full_window, a_valid_reg |-> (count_reg >= CNT_W'(WIN_LEN)),
                "result from a partial window")
    `PCW_ASSERT(a_stall_holds_stage,
                (m_tvalid && !m_tready) |=> ($stable(a_valid_reg) && $stable(m_idx_reg)),
                "pipeline moved while stalled")

endmodule

`default_nettype wire

FILE: rtl/pcw_cell.sv
// ----------------------------------------------------------------------------
// pcw_cell
// One window slot: holds a point and hands it to its older neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pcw_cell #(
    parameter int POINT_W = 54
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               shift,
    input  wire logic [POINT_W-1:0] point_in,
    output logic      [POINT_W-1:0] point_out
);

    logic [POINT_W-1:0] point_reg;

    // Clear on reset so the running window sums start consistent
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_reg <= '0;
        end else if (shift) begin
            point_reg <= point_in;
        end
    end

    assign point_out = point_reg;

endmodule

`default_nettype wire

FILE: rtl/pcw_axis.sv
// ----------------------------------------------------------------------------
// pcw_axis
// Per-axis running window sum, centre difference and its square.
// ----------------------------------------------------------------------------
`default_nettype none

module pcw_axis #(
    parameter int COORD_BITS  = 18,
    parameter int HALF_WINDOW = 5
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire pcw_pkg::pcw_ctrl_t       ctrl,
    input  wire logic signed [COORD_BITS-1:0] new_coord,
    input  wire logic signed [COORD_BITS-1:0] old_coord,
    input  wire logic signed [COORD_BITS-1:0] centre_coord,
    output logic [2*(COORD_BITS+$clog2(4*HALF_WINDOW)+1)-1:0] square
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int TOT_W   = COORD_BITS + $clog2(WIN_LEN) + 1;
    localparam int DIFF_W  = COORD_BITS + $clog2(4 * HALF_WINDOW) + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam logic signed [DIFF_W-1:0] CENTRE_GAIN = DIFF_W'(WIN_LEN);

    logic signed [TOT_W-1:0]  total_reg;
    logic signed [TOT_W-1:0]  total_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic        [DIFF_W-1:0] mag;
    logic        [SQ_W-1:0]   square_reg;
    logic        [SQ_W-1:0]   square_next;

    // Window sum: add the arriving point, drop the one leaving
    assign total_next = total_reg + TOT_W'(new_coord) - TOT_W'(old_coord);

    // Neighbor sum minus 2*HALF_WINDOW x centre = whole sum minus WIN_LEN x centre
    assign diff_next = DIFF_W'(total_reg) - DIFF_W'(centre_coord) * CENTRE_GAIN;

    assign mag         = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign square_next = SQ_W'(mag) * SQ_W'(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (ctrl.shift) begin
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            diff_reg   <= diff_next;
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule

`default_nettype wire

FILE: dv/point_curvature_window_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_curvature_window_checker
// Watches both stream channels of the curvature window, keeps its own copy
// of the point window, and compares every result transfer with the oldest
// predicted curvature.
// ----------------------------------------------------------------------------
module point_curvature_window_checker #(
    parameter int HALF_WINDOW = 5,
    parameter int MAX_POINTS  = 65536
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [pcw_pkg::S_TDATA_W-1:0] s_tdata,  // x_mm, y_mm, z_mm, zero pad
    input  wire logic                          s_tuser,  // cloud_start
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [pcw_pkg::M_TDATA_W-1:0] m_tdata,  // centre_index, curvature, zero pad
    output int                                 fail_count,
    output int                                 outstanding
);
    import pcw_pkg::*;

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int PAD_W   = M_TDATA_W - IDX_W - CURV_W;

    typedef struct packed {
        logic [IDX_W-1:0]  centre_index;
        logic [CURV_W-1:0] curvature;
    } curv_result_t;

    logic signed [IN_COORD_W-1:0] window_pts [WIN_LEN][3];
    int                           points_in_cloud;
    curv_result_t                 curvature_due_q [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch: %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void clear_window();
        for (int k = 0; k < WIN_LEN; k++) begin
            for (int ax = 0; ax < 3; ax++) begin
                window_pts[k][ax] = '0;
            end
        end
        points_in_cloud = 0;
    endfunction

    // Shift one accepted point in and queue the curvature it makes, if any
    function automatic void window_curvature(input logic [S_TDATA_W-1:0] data,
                                             input logic start);
        curv_result_t        due;
        longint              axis_sum;
        longint unsigned     curv_sum;
        if (start) begin
            points_in_cloud = 0;
        end
        // cloud too long: drop the point, window untouched
        if (points_in_cloud >= MAX_POINTS) begin
            return;
        end
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            window_pts[k] = window_pts[k + 1];
        end
        for (int ax = 0; ax < 3; ax++) begin
            window_pts[WIN_LEN - 1][ax] = data[ax * IN_COORD_W +: IN_COORD_W];
        end
        points_in_cloud++;
        if (points_in_cloud < WIN_LEN) begin
            return;
        end
        curv_sum = 0;
        for (int ax = 0; ax < 3; ax++) begin
            axis_sum = 0;
            for (int k = 0; k < WIN_LEN; k++) begin
                if (k != HALF_WINDOW) begin
                    axis_sum += longint'(window_pts[k][ax]);
                end
            end
            axis_sum -= 2 * HALF_WINDOW * longint'(window_pts[HALF_WINDOW][ax]);
            curv_sum += axis_sum * axis_sum;
        end
        due.centre_index = IDX_W'(points_in_cloud - 1 - HALF_WINDOW);
        due.curvature    = CURV_W'(curv_sum);
        curvature_due_q.insert(curvature_due_q.size(), due);
    endfunction

    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        curv_result_t want;
        if (curvature_due_q.size() == 0) begin
            report_mismatch("result with none expected, centre_index",
                            64'(data[IDX_W-1:0]), '0);
            return;
        end
        want = curvature_due_q.pop_front();
        if (data[IDX_W-1:0] !== want.centre_index) begin
            report_mismatch("centre_index", 64'(data[IDX_W-1:0]),
                            64'(want.centre_index));
        end
        if (data[IDX_W +: CURV_W] !== want.curvature) begin
            report_mismatch($sformatf("curvature at index %0d", want.centre_index),
                            64'(data[IDX_W +: CURV_W]), 64'(want.curvature));
        end
        if (data[M_TDATA_W-1 -: PAD_W] !== '0) begin
            report_mismatch("m_tdata pad", 64'(data[M_TDATA_W-1 -: PAD_W]), '0);
        end
    endtask

    // Compare first: a result never belongs to a point taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_window();
            curvature_due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                window_curvature(s_tdata, s_tuser);
            end
        end
        outstanding <= curvature_due_q.size();
    end

endmodule

FILE: dv/point_curvature_window_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_curvature_window_tb
// Drives lidar points into the curvature window: a short directed run of
// extreme and cloud-boundary points, random clouds under three idle patterns,
// and one closing clean cloud. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module point_curvature_window_tb;
    import pcw_pkg::*;

    localparam int HALF_WINDOW  = 5;
    localparam int COORD_BITS   = 18;
    localparam int MAX_POINTS   = 65536;
    localparam int DRAIN_CYCLES = 16;      // pipeline is four deep; leave margin
    localparam int DRAIN_LIMIT  = 20000;

    typedef logic signed [IN_COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(IN_COORD_W - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(IN_COORD_W - 1){1'b0}}};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // x_mm, y_mm, z_mm, zero pad
    logic                 s_tuser  = 1'b0; // cloud_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // centre_index, curvature, zero pad

    int fail_count;
    int outstanding;
    int src_idle_pct  = 25;
    int sink_idle_pct = 69;
    int wait_cycles;

    point_curvature_window #(
        .HALF_WINDOW (HALF_WINDOW),
        .COORD_BITS  (COORD_BITS),
        .MAX_POINTS  (MAX_POINTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    point_curvature_window_checker #(
        .HALF_WINDOW (HALF_WINDOW),
        .MAX_POINTS  (MAX_POINTS)
    ) curv_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Stall the result side at random; the current phase sets how often
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("timeout with %0d results still due", outstanding);
        $display("** point_curvature_window: FAILED **");
        $finish;
    end

    // Mix extremes, full-range noise and small near-origin values
    function automatic coord_t pick_coord();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3, 4: return coord_t'($urandom);
            default:    return coord_t'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Hold one point on the bus until its transfer; idle first at random
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({z, y, x});
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold off until every predicted curvature has left
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // One cloud; with strays set, a rare cloud_start breaks it midway
    task automatic send_cloud(input int n_pts, input bit strays);
        logic start;
        for (int i = 0; i < n_pts; i++) begin
            start = (i == 0) || (strays && $urandom_range(99) < 2);
            send_point(pick_coord(), pick_coord(), pick_coord(), start);
        end
    endtask

    // Random clouds, mostly long enough to give results, some too short
    task automatic run_clouds(input int n_target);
        int sent_here;
        int len;
        bit paused;
        sent_here = 0;
        paused    = 0;
        while (sent_here < n_target) begin
            len = ($urandom_range(99) < 15) ? $urandom_range(1, 10)
                                            : $urandom_range(11, 40);
            send_cloud(len, 1'b1);
            sent_here += len;
            if (!paused && sent_here >= n_target / 2) begin
                drain_results();
                paused = 1;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Largest curvature: neighbours at one extreme, centre at the other
        for (int i = 0; i < 2 * HALF_WINDOW + 1; i++) begin
            if (i == HALF_WINDOW) begin
                send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
            end else begin
                send_point(COORD_MAX, COORD_MIN, COORD_MAX, i == 0);
            end
        end
        send_point('0, '0, '0, 1'b0);
        send_point('1, '1, '1, 1'b0);
        // Short cloud: no result may come out of it
        send_point(COORD_MIN, '0, COORD_MAX, 1'b1);
        for (int i = 0; i < 4; i++) begin
            send_point(coord_t'(i), coord_t'(-i), COORD_MAX, 1'b0);
        end
        // Back-to-back cloud starts: a lone point, then a fresh cloud
        send_point('1, '0, COORD_MAX, 1'b1);
        send_point(COORD_MAX, COORD_MIN, '1, 1'b1);
        for (int i = 0; i < 5; i++) begin
            send_point(COORD_MIN, COORD_MAX, coord_t'(i), 1'b0);
        end

        // Sender idles lightly, receiver stalls heavily
        run_clouds(600);
        // Swap the pressure
        src_idle_pct  = 69;
        sink_idle_pct = 25;
        run_clouds(600);
        // Full rate both ways
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_clouds(590);

        // Close with one clean cloud
        send_cloud(14, 1'b0);
        s_tvalid <= 1'b0;

        for (wait_cycles = 0; outstanding != 0 && wait_cycles < DRAIN_LIMIT;
             wait_cycles++) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("** point_curvature_window: PASSED **");
        end else begin
            if (outstanding != 0) begin
                $display("%0d results never arrived", outstanding);
            end
            $display("** point_curvature_window: FAILED **");
        end
        $finish;
    end

endmodule
